>>> src/p3dx_pkg.sv
// p3dx_pkg: shared types and constants for the 3D point transform core.
// Holds mode and register index codes, lane control and stage enable structs.
// No dependencies.
package p3dx_pkg;

    // Fixed coefficient format: 16-bit signed, scale factor is Q8.8
    localparam int COEF_BITS       = 16;
    localparam int SCALE_FRAC_BITS = 8;
    localparam int MODE_BITS       = 3;
    localparam int CFG_INDEX_BITS  = 3;

    // Transform modes; codes 5 to 7 pass the point through
    typedef enum logic [MODE_BITS-1:0] {
        MODE_SCALE     = 3'd0,
        MODE_TRANSLATE = 3'd1,
        MODE_ROT_X     = 3'd2,
        MODE_ROT_Y     = 3'd3,
        MODE_ROT_Z     = 3'd4
    } mode_t;

    // Configuration register indexes; index 7 is ignored
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_MODE     = 3'd0,
        REG_SCALE    = 3'd1,
        REG_COSINE   = 3'd2,
        REG_SINE     = 3'd3,
        REG_CENTER_X = 3'd4,
        REG_CENTER_Y = 3'd5,
        REG_CENTER_Z = 3'd6
    } reg_index_t;

    // Reset values
    localparam logic [MODE_BITS-1:0]        MODE_RESET   = MODE_SCALE;
    localparam logic signed [COEF_BITS-1:0] SCALE_RESET  = 16'sd256;
    localparam logic signed [COEF_BITS-1:0] COSINE_RESET = 16'sd16384;
    localparam logic signed [COEF_BITS-1:0] SINE_RESET   = 16'sd0;

    // Per-lane operation
    typedef enum logic [1:0] {
        OP_PASS  = 2'd0,
        OP_SCALE = 2'd1,
        OP_ROT   = 2'd2
    } op_t;

    typedef struct packed {
        op_t  op;
        logic sub;      // subtract the second product
    } lane_ctl_t;

    // Load enables for the lane stages
    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
    } pipe_en_t;

endpackage

>>> src/p3dx_cfg_regs.sv
// p3dx_cfg_regs: configuration register file (mode, scale, cosine, sine, center).
// Depends on p3dx_pkg.
module p3dx_cfg_regs #(
    parameter int COORD_BITS = 24,
    parameter int CFG_BITS   = 24
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [p3dx_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [CFG_BITS-1:0]                     cfg_data,
    output logic [p3dx_pkg::MODE_BITS-1:0]          mode,
    output logic signed [p3dx_pkg::COEF_BITS-1:0]   scale_factor,
    output logic signed [p3dx_pkg::COEF_BITS-1:0]   cosine,
    output logic signed [p3dx_pkg::COEF_BITS-1:0]   sine,
    output logic signed [COORD_BITS-1:0]            center_x,
    output logic signed [COORD_BITS-1:0]            center_y,
    output logic signed [COORD_BITS-1:0]            center_z
);
    import p3dx_pkg::*;

    logic [MODE_BITS-1:0]        mode_reg;
    logic signed [COEF_BITS-1:0] scale_reg;
    logic signed [COEF_BITS-1:0] cosine_reg;
    logic signed [COEF_BITS-1:0] sine_reg;
    logic signed [COORD_BITS-1:0] center_x_reg;
    logic signed [COORD_BITS-1:0] center_y_reg;
    logic signed [COORD_BITS-1:0] center_z_reg;

    // Writes are always accepted
    assign cfg_ready = 1'b1;

    // Register writes; upper data bits beyond a register's width are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_RESET;
            scale_reg    <= SCALE_RESET;
            cosine_reg   <= COSINE_RESET;
            sine_reg     <= SINE_RESET;
            center_x_reg <= '0;
            center_y_reg <= '0;
            center_z_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_MODE:     mode_reg     <= cfg_data[MODE_BITS-1:0];
                REG_SCALE:    scale_reg    <= cfg_data[COEF_BITS-1:0];
                REG_COSINE:   cosine_reg   <= cfg_data[COEF_BITS-1:0];
                REG_SINE:     sine_reg     <= cfg_data[COEF_BITS-1:0];
                REG_CENTER_X: center_x_reg <= cfg_data[COORD_BITS-1:0];
                REG_CENTER_Y: center_y_reg <= cfg_data[COORD_BITS-1:0];
                REG_CENTER_Z: center_z_reg <= cfg_data[COORD_BITS-1:0];
                default:      ;
            endcase
        end
    end

    assign mode         = mode_reg;
    assign scale_factor = scale_reg;
    assign cosine       = cosine_reg;
    assign sine         = sine_reg;
    assign center_x     = center_x_reg;
    assign center_y     = center_y_reg;
    assign center_z     = center_z_reg;

endmodule

>>> src/p3dx_lane.sv
// p3dx_lane: one coordinate lane: multiply, sum and round, add center, saturate.
// Stages 2 to 4 of the pipeline. Depends on p3dx_pkg.
module p3dx_lane #(
    parameter int COORD_BITS     = 24,
    parameter int TRIG_FRAC_BITS = 14
) (
    input  logic                                    clk,
    input  p3dx_pkg::pipe_en_t                      en,
    input  p3dx_pkg::lane_ctl_t                     ctl,
    input  logic signed [COORD_BITS:0]              opa,
    input  logic signed [COORD_BITS:0]              opb,
    input  logic signed [p3dx_pkg::COEF_BITS-1:0]   coef_a,
    input  logic signed [p3dx_pkg::COEF_BITS-1:0]   coef_b,
    input  logic signed [COORD_BITS:0]              pass_val,
    input  logic signed [COORD_BITS-1:0]            base,
    output logic signed [COORD_BITS-1:0]            result,
    output logic                                    sat_flag
);
    import p3dx_pkg::*;

    localparam int PROD_BITS = COORD_BITS + 1 + COEF_BITS;
    localparam int SUM_BITS  = PROD_BITS + 1;
    localparam int VAL_BITS  = SUM_BITS + 1;

    localparam logic signed [SUM_BITS-1:0] HALF_SCALE = SUM_BITS'(1) << (SCALE_FRAC_BITS - 1);
    localparam logic signed [SUM_BITS-1:0] HALF_ROT   = SUM_BITS'(1) << (TRIG_FRAC_BITS - 1);
    localparam logic signed [VAL_BITS-1:0] SAT_MAX    =
        {{(VAL_BITS - COORD_BITS + 1){1'b0}}, {(COORD_BITS - 1){1'b1}}};
    localparam logic signed [VAL_BITS-1:0] SAT_MIN    = ~SAT_MAX;

    // Stage 2: products
    logic signed [PROD_BITS-1:0]  p1_reg, p2_reg, p1_next, p2_next;
    lane_ctl_t                    ctl2_reg;
    logic signed [COORD_BITS:0]   pass2_reg;
    logic signed [COORD_BITS-1:0] base2_reg;

    assign p1_next = PROD_BITS'(opa) * PROD_BITS'(coef_a);
    assign p2_next = PROD_BITS'(opb) * PROD_BITS'(coef_b);

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            p1_reg    <= p1_next;
            p2_reg    <= p2_next;
            ctl2_reg  <= ctl;
            pass2_reg <= pass_val;
            base2_reg <= base;
        end
    end

    // Stage 3: sum or difference of products, add half an LSB, floor shift
    logic signed [SUM_BITS-1:0]   sum_ab, sum_rnd, q_next, q3_reg;
    op_t                          op3_reg;
    logic signed [COORD_BITS:0]   pass3_reg;
    logic signed [COORD_BITS-1:0] base3_reg;

    always_comb
    begin
        if (ctl2_reg.sub)
            sum_ab = SUM_BITS'(p1_reg) - SUM_BITS'(p2_reg);
        else
            sum_ab = SUM_BITS'(p1_reg) + SUM_BITS'(p2_reg);
        if (ctl2_reg.op == OP_SCALE)
        begin
            sum_rnd = sum_ab + HALF_SCALE;
            q_next  = sum_rnd >>> SCALE_FRAC_BITS;
        end
        else
        begin
            sum_rnd = sum_ab + HALF_ROT;
            q_next  = sum_rnd >>> TRIG_FRAC_BITS;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            q3_reg    <= q_next;
            op3_reg   <= ctl2_reg.op;
            pass3_reg <= pass2_reg;
            base3_reg <= base2_reg;
        end
    end

    // Stage 4: add center (or take the pass value), saturate to the coordinate range
    logic signed [VAL_BITS-1:0]   val;
    logic signed [COORD_BITS-1:0] res_next, res_reg;
    logic                         sat_next, sat_reg;

    always_comb
    begin
        if (op3_reg == OP_PASS)
            val = VAL_BITS'(pass3_reg);
        else
            val = VAL_BITS'(q3_reg) + VAL_BITS'(base3_reg);
        if (val > SAT_MAX)
        begin
            res_next = SAT_MAX[COORD_BITS-1:0];
            sat_next = 1'b1;
        end
        else if (val < SAT_MIN)
        begin
            res_next = SAT_MIN[COORD_BITS-1:0];
            sat_next = 1'b1;
        end
        else
        begin
            res_next = val[COORD_BITS-1:0];
            sat_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s4)
        begin
            res_reg <= res_next;
            sat_reg <= sat_next;
        end
    end

    assign result   = res_reg;
    assign sat_flag = sat_reg;

endmodule

>>> src/point3d_affine_transform_core.sv
// point3d_affine_transform_core: top level of the 3D point scale/translate/rotate core.
// Depends on p3dx_pkg, p3dx_cfg_regs and p3dx_lane.
//
//  Port group  | Direction | Handshake            | Payload
//  ------------+-----------+----------------------+------------------------------
//  input       | in        | in_valid / in_ready  | in_x, in_y, in_z
//  output      | out       | out_valid/ out_ready | out_x, out_y, out_z, overflow
//  config      | in        | cfg_valid/ cfg_ready | cfg_index, cfg_data
//
// One point per cycle sustained while out_ready stays high; an input transaction passes
// through the difference stage, multiply stage, round stage and offset/saturate stage
// in that order, and out_valid rises when the offset/saturate stage holds it.
// Every stage holds its own valid bit; a stage loads whenever it is empty or the
// stage after it moves, so bubbles close up under stall and nothing is dropped.
// Reset clears the valid bits and loads the register defaults; cfg_ready is always high.
module point3d_affine_transform_core #(
    parameter int COORD_BITS     = 24,
    parameter int TRIG_FRAC_BITS = 14,
    localparam int CFG_BITS      = (COORD_BITS > p3dx_pkg::COEF_BITS) ?
                                   COORD_BITS : p3dx_pkg::COEF_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [COORD_BITS-1:0]        in_x,
    input  logic signed [COORD_BITS-1:0]        in_y,
    input  logic signed [COORD_BITS-1:0]        in_z,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [COORD_BITS-1:0]        out_x,
    output logic signed [COORD_BITS-1:0]        out_y,
    output logic signed [COORD_BITS-1:0]        out_z,
    output logic                                overflow,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [p3dx_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]                 cfg_data
);
    import p3dx_pkg::*;

    localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS - 1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] COORD_MIN = ~COORD_MAX;

    // Configuration registers
    logic [MODE_BITS-1:0]         mode;
    logic signed [COEF_BITS-1:0]  scale_factor, cosine, sine;
    logic signed [COORD_BITS-1:0] center_x, center_y, center_z;

    p3dx_cfg_regs #(
        .COORD_BITS (COORD_BITS),
        .CFG_BITS   (CFG_BITS)
    ) u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mode         (mode),
        .scale_factor (scale_factor),
        .cosine       (cosine),
        .sine         (sine),
        .center_x     (center_x),
        .center_y     (center_y),
        .center_z     (center_z)
    );

    // Pipeline flow control
    logic     v1_reg, v2_reg, v3_reg, v4_reg;
    logic     ready1, ready2, ready3, ready4;
    pipe_en_t en;

    assign ready4   = !v4_reg || out_ready;
    assign ready3   = !v3_reg || ready4;
    assign ready2   = !v2_reg || ready3;
    assign ready1   = !v1_reg || ready2;
    assign in_ready = ready1;

    assign en.s2 = v1_reg && ready2;
    assign en.s3 = v2_reg && ready3;
    assign en.s4 = v3_reg && ready4;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
                v1_reg <= in_valid;
            if (ready2)
                v2_reg <= v1_reg;
            if (ready3)
                v3_reg <= v2_reg;
            if (ready4)
                v4_reg <= v3_reg;
        end
    end

    // Stage 1: differences to the center, pass-through values
    logic signed [COORD_BITS:0] dx_reg, dy_reg, dz_reg;
    logic signed [COORD_BITS:0] px_reg, py_reg, pz_reg;
    logic signed [COORD_BITS:0] px_next, py_next, pz_next;
    logic [MODE_BITS-1:0]       mode1_reg;

    always_comb
    begin
        if (mode == MODE_TRANSLATE)
        begin
            px_next = (COORD_BITS+1)'(in_x) + (COORD_BITS+1)'(center_x);
            py_next = (COORD_BITS+1)'(in_y) + (COORD_BITS+1)'(center_y);
            pz_next = (COORD_BITS+1)'(in_z) + (COORD_BITS+1)'(center_z);
        end
        else
        begin
            px_next = (COORD_BITS+1)'(in_x);
            py_next = (COORD_BITS+1)'(in_y);
            pz_next = (COORD_BITS+1)'(in_z);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && ready1)
        begin
            dx_reg    <= (COORD_BITS+1)'(in_x) - (COORD_BITS+1)'(center_x);
            dy_reg    <= (COORD_BITS+1)'(in_y) - (COORD_BITS+1)'(center_y);
            dz_reg    <= (COORD_BITS+1)'(in_z) - (COORD_BITS+1)'(center_z);
            px_reg    <= px_next;
            py_reg    <= py_next;
            pz_reg    <= pz_next;
            mode1_reg <= mode;
        end
    end

    // Operand routing per lane
    lane_ctl_t                   ctl_x, ctl_y, ctl_z;
    logic signed [COORD_BITS:0]  ax, bx, ay, by, az, bz;
    logic signed [COEF_BITS-1:0] kax, kbx, kay, kby, kaz, kbz;

    always_comb
    begin
        ctl_x = '{op: OP_PASS, sub: 1'b0};
        ctl_y = '{op: OP_PASS, sub: 1'b0};
        ctl_z = '{op: OP_PASS, sub: 1'b0};
        ax = dx_reg;  bx = dy_reg;  kax = cosine;  kbx = sine;
        ay = dy_reg;  by = dz_reg;  kay = cosine;  kby = sine;
        az = dz_reg;  bz = dx_reg;  kaz = cosine;  kbz = sine;
        unique case (mode1_reg)
            MODE_SCALE:
            begin
                ctl_x = '{op: OP_SCALE, sub: 1'b0};
                ctl_y = '{op: OP_SCALE, sub: 1'b0};
                ctl_z = '{op: OP_SCALE, sub: 1'b0};
                kax = scale_factor;  kbx = '0;
                kay = scale_factor;  kby = '0;
                kaz = scale_factor;  kbz = '0;
            end
            MODE_ROT_X:
            begin
                // y' = dy*c + dz*s, z' = dz*c - dy*s
                ctl_y = '{op: OP_ROT, sub: 1'b0};
                ctl_z = '{op: OP_ROT, sub: 1'b1};
                bz    = dy_reg;
            end
            MODE_ROT_Y:
            begin
                // x' = dx*c - dz*s, z' = dz*c + dx*s
                ctl_x = '{op: OP_ROT, sub: 1'b1};
                ctl_z = '{op: OP_ROT, sub: 1'b0};
                bx    = dz_reg;
            end
            MODE_ROT_Z:
            begin
                // x' = dx*c + dy*s, y' = dy*c - dx*s
                ctl_x = '{op: OP_ROT, sub: 1'b0};
                ctl_y = '{op: OP_ROT, sub: 1'b1};
                by    = dx_reg;
            end
            default: ;  // translate and unused codes pass through
        endcase
    end

    // Stages 2 to 4, one lane per coordinate
    logic sat_x, sat_y, sat_z;

    p3dx_lane #(
        .COORD_BITS     (COORD_BITS),
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_lane_x (
        .clk (clk), .en (en), .ctl (ctl_x),
        .opa (ax), .opb (bx), .coef_a (kax), .coef_b (kbx),
        .pass_val (px_reg), .base (center_x),
        .result (out_x), .sat_flag (sat_x)
    );

    p3dx_lane #(
        .COORD_BITS     (COORD_BITS),
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_lane_y (
        .clk (clk), .en (en), .ctl (ctl_y),
        .opa (ay), .opb (by), .coef_a (kay), .coef_b (kby),
        .pass_val (py_reg), .base (center_y),
        .result (out_y), .sat_flag (sat_y)
    );

    p3dx_lane #(
        .COORD_BITS     (COORD_BITS),
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_lane_z (
        .clk (clk), .en (en), .ctl (ctl_z),
        .opa (az), .opb (bz), .coef_a (kaz), .coef_b (kbz),
        .pass_val (pz_reg), .base (center_z),
        .result (out_z), .sat_flag (sat_z)
    );

    assign out_valid = v4_reg;
    assign overflow  = sat_x || sat_y || sat_z;

    // An empty output stage always lets a new transaction in
    a_ready_when_out_empty: assert property (
        @(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready
    ) else $error("input stalled with empty output stage");

    // A full pipeline facing a stalled sink must not accept
    a_full_blocks_input: assert property (
        @(posedge clk) disable iff (!rst_n)
        (v1_reg && v2_reg && v3_reg && v4_reg && !out_ready) |-> !in_ready
    ) else $error("input accepted while pipeline full and stalled");

    // A stage only fills from the stage before it
    a_stage2_from_stage1: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(v2_reg) |-> $past(v1_reg)
    ) else $error("stage 2 filled without stage 1 data");

    a_stage4_from_stage3: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(v4_reg) |-> $past(v3_reg)
    ) else $error("output stage filled without stage 3 data");

    // Overflow means at least one coordinate sits on a rail
    a_overflow_on_rail: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && overflow) |->
            (out_x == COORD_MAX || out_x == COORD_MIN ||
             out_y == COORD_MAX || out_y == COORD_MIN ||
             out_z == COORD_MAX || out_z == COORD_MIN)
    ) else $error("overflow set with no saturated coordinate");

endmodule
